// ----- src/frac_pkg.sv -----
// ----------------------------------------------------------------------------
// frac_pkg
// Shared constants and types for the fraction reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package frac_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_GCD_WAIT,
		ST_QN_WAIT,
		ST_QD_WAIT,
		ST_OUT
	} fsm_state_t;

endpackage

`default_nettype wire

// ----- src/frac_if.sv -----
// ----------------------------------------------------------------------------
// frac_if
// Valid/ready channels for fraction beats in and reduced fraction beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface frac_in_if #(
	parameter int unsigned DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] numerator;
	logic signed [DATA_WIDTH-1:0] denominator;

	modport source (output valid, output numerator, output denominator, input ready);
	modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface frac_out_if #(
	parameter int unsigned DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] reduced_numerator;
	logic        [DATA_WIDTH-2:0] reduced_denominator;
	logic                         is_whole;
	logic                         div_by_zero;

	modport source (output valid, output reduced_numerator, output reduced_denominator,
		output is_whole, output div_by_zero, input ready);
	modport sink   (input valid, input reduced_numerator, input reduced_denominator,
		input is_whole, input div_by_zero, output ready);
endinterface

`default_nettype wire

// ----- src/frac_div.sv -----
// ----------------------------------------------------------------------------
// frac_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_div import frac_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] dividend,
	input  wire logic [DATA_WIDTH-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      quotient,
	output logic [DATA_WIDTH-1:0]      remainder
);

	localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] dsr_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH-1:0] rem_nxt;

	always_comb begin
		shifted = {rem_q, quo_q[DATA_WIDTH-1]};
		diff    = shifted - {1'b0, dsr_q};
		rem_nxt = diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ----- src/fraction_reducer_top.sv -----
// ----------------------------------------------------------------------------
// fraction_reducer_top
// Reduces a signed fraction to lowest terms via Euclid's remainder loop.
// ----------------------------------------------------------------------------
// Euclid steps: up to about 46 at 32 bits; a zero denominator skips the
//   divider and goes straight to the result beat.
// Throughput: one beat at a time; the next beat can be taken in the cycle
//   after the result beat. Euclid steps and both final quotients run on
//   the shared bit-serial divider.
// Reset: arst_n clears the sequencer and divider control; no beat pending.
`default_nettype none

module fraction_reducer_top import frac_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	frac_in_if.sink   req,
	frac_out_if.source rsp
);

	localparam int unsigned W = DATA_WIDTH;

	fsm_state_t state_q, state_d;

	logic [W-1:0] an_q, ad_q, a_q, b_q, qn_q, qd_q;
	logic         neg_q, err_q;

	logic         div_start, div_busy, div_done;
	logic [W-1:0] div_dividend, div_divisor, div_quo, div_rem;
	logic [W-1:0] mag_num, mag_den;
	logic         accept;

	frac_div #(.DATA_WIDTH(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		mag_num = req.numerator[W-1] ? W'(-req.numerator) : W'(req.numerator);
		mag_den = req.denominator[W-1] ? W'(-req.denominator) : W'(req.denominator);
		accept  = req.valid && req.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req.ready    = 1'b0;
		rsp.valid    = 1'b0;
		div_start    = 1'b0;
		div_dividend = a_q;
		div_divisor  = b_q;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (req.denominator == '0) ? ST_OUT : ST_GCD;
				end
			end
			ST_GCD: begin
				div_start = 1'b1;
				if (b_q == '0) begin
					div_dividend = an_q;
					div_divisor  = a_q;
					state_d      = ST_QN_WAIT;
				end else begin
					state_d = ST_GCD_WAIT;
				end
			end
			ST_GCD_WAIT: begin
				if (div_done) begin
					state_d = ST_GCD;
				end
			end
			ST_QN_WAIT: begin
				div_dividend = ad_q;
				div_divisor  = a_q;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_QD_WAIT;
				end
			end
			ST_QD_WAIT: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				rsp.valid = 1'b1;
				if (rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			an_q  <= mag_num;
			ad_q  <= mag_den;
			a_q   <= mag_num;
			b_q   <= mag_den;
			neg_q <= req.numerator[W-1] ^ req.denominator[W-1];
			err_q <= (req.denominator == '0);
			qn_q  <= '0;
			qd_q  <= '0;
		end else if (div_done) begin
			priority case (state_q)
				ST_GCD_WAIT: begin
					a_q <= b_q;
					b_q <= div_rem;
				end
				ST_QN_WAIT: qn_q <= div_quo;
				ST_QD_WAIT: qd_q <= div_quo;
				default: ;
			endcase
		end
	end

	always_comb begin
		rsp.reduced_numerator   = neg_q ? -qn_q : qn_q;
		rsp.reduced_denominator = qd_q[W-2:0];
		rsp.is_whole            = (qd_q == W'(1));
		rsp.div_by_zero         = err_q;
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("input taken while a result is pending");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GCD) |-> (a_q != '0 || b_q != '0))
		else $error("gcd operands both zero");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.div_by_zero) |->
		(rsp.reduced_numerator == '0 && rsp.reduced_denominator == '0 && !rsp.is_whole))
		else $error("error result carries nonzero fields");

	a_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.is_whole) |-> (rsp.reduced_denominator == (W-1)'(1)))
		else $error("whole flag with denominator other than one");

endmodule

`default_nettype wire

// ----- tb/tb_fraction_reducer_top.sv -----
// ----------------------------------------------------------------------------
// tb_fraction_reducer_top
// Self-checking bench for the fraction reducer. A short table of directed
// fractions covers zero numerators and denominators, the field extremes and
// the most negative value. Sixteen rows carry hand-derived results and the
// other nine go through a built-in reduction predictor. About 925 random
// fractions follow. They mix shared factors, long Euclid chains, powers of
// two, small values and raw bit patterns. Both channels idle at random. The
// bench also applies one long output stall and one full drain of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fraction_reducer_top;
	import frac_pkg::*;

	localparam int unsigned W              = DATA_WIDTH_DEF;
	localparam int unsigned NUM_DIRECTED   = 25;
	localparam int unsigned NUM_RANDOM     = 925;
	localparam int unsigned HOLD_CYCLES    = 2000;
	localparam int unsigned SETTLE_CYCLES  = 2000;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	localparam logic [W-1:0] MAXP     = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NEG_MAXP = {1'b1, {(W-2){1'b0}}, 1'b1};
	localparam logic [W-1:0] MOSTNEG  = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] NEG_ONE  = '1;

	typedef struct packed {
		logic signed [W-1:0] rnum;
		logic        [W-2:0] rden;
		logic                whole;
		logic                dbz;
	} frac_res_t;

	typedef struct packed {
		logic [W-1:0] num;
		logic [W-1:0] den;
		logic         typed;
		frac_res_t    res;
	} frac_row_t;

	localparam frac_res_t NO_RES  = '0;
	localparam frac_res_t DBZ_RES = '{'0, '0, 1'b0, 1'b1};

	localparam frac_row_t DIRECTED [NUM_DIRECTED] = '{
		'{32'd0,          32'd0,          1'b1, DBZ_RES},
		'{MAXP,           32'd0,          1'b1, DBZ_RES},
		'{NEG_MAXP,       32'd0,          1'b1, DBZ_RES},
		'{MOSTNEG,        32'd0,          1'b1, DBZ_RES},
		'{32'd0,          32'd5,          1'b1, '{32'sd0, 31'd1, 1'b1, 1'b0}},
		'{32'd0,          -32'sd7,        1'b1, '{32'sd0, 31'd1, 1'b1, 1'b0}},
		'{MAXP,           32'd1,          1'b1, '{32'sh7FFFFFFF, 31'd1, 1'b1, 1'b0}},
		'{MAXP,           MAXP,           1'b1, '{32'sd1, 31'd1, 1'b1, 1'b0}},
		'{NEG_MAXP,       MAXP,           1'b1, '{-32'sd1, 31'd1, 1'b1, 1'b0}},
		'{MAXP,           NEG_MAXP,       1'b1, '{-32'sd1, 31'd1, 1'b1, 1'b0}},
		'{32'd1,          MAXP,           1'b1, '{32'sd1, 31'h7FFFFFFF, 1'b0, 1'b0}},
		'{NEG_ONE,        NEG_MAXP,       1'b1, '{32'sd1, 31'h7FFFFFFF, 1'b0, 1'b0}},
		'{MOSTNEG,        NEG_ONE,        1'b1, '{32'sh80000000, 31'd1, 1'b1, 1'b0}},
		'{32'd1,          MOSTNEG,        1'b1, '{-32'sd1, 31'd0, 1'b0, 1'b0}},
		'{MOSTNEG,        MOSTNEG,        1'b1, '{32'sd1, 31'd1, 1'b1, 1'b0}},
		'{MOSTNEG,        32'd1,          1'b1, '{32'sh80000000, 31'd1, 1'b1, 1'b0}},
		'{32'd12,         -32'sd18,       1'b0, NO_RES},
		'{-32'sd6,        32'd4,          1'b0, NO_RES},
		'{-32'sd6,        -32'sd4,        1'b0, NO_RES},
		'{32'd1836311903, 32'd1134903170, 1'b0, NO_RES},
		'{-32'sd1134903170, 32'd701408733, 1'b0, NO_RES},
		'{32'd7,          32'd3,          1'b0, NO_RES},
		'{32'h40000000,   32'h00100000,   1'b0, NO_RES},
		'{MOSTNEG,        32'd2,          1'b0, NO_RES},
		'{32'h55555555,   32'hAAAAAAAA,   1'b0, NO_RES}
	};

	localparam logic [W-1:0] EXTREMES [8] = '{
		32'd0, 32'd1, NEG_ONE, 32'd2, -32'sd2, MAXP, NEG_MAXP, MOSTNEG
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	frac_in_if  #(.DATA_WIDTH(W)) req_if ();
	frac_out_if #(.DATA_WIDTH(W)) rsp_if ();

	fraction_reducer_top #(.DATA_WIDTH(W)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	frac_res_t   reduced_q [$];
	int unsigned mismatches = 0;
	int unsigned sent_beats = 0;
	int unsigned idle_cycles = 0;
	bit          send_idle = 1'b1;
	bit          rsp_hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic frac_res_t reduce_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
		frac_res_t  r;
		logic [W:0] an, ad, a, b, t, qn, qd;
		logic       neg;
		r = '0;
		if (d == '0) begin
			r.dbz = 1'b1;
			return r;
		end
		an = n[W-1] ? {1'b0, ~n + 1'b1} : {1'b0, n};
		ad = d[W-1] ? {1'b0, ~d + 1'b1} : {1'b0, d};
		a = an;
		b = ad;
		while (b != '0) begin
			t = a % b;
			a = b;
			b = t;
		end
		qn = an / a;
		qd = ad / a;
		neg = n[W-1] ^ d[W-1];
		r.rnum = neg ? (~qn[W-1:0] + 1'b1) : qn[W-1:0];
		r.rden = qd[W-2:0];
		r.whole = (qd == 1);
		return r;
	endfunction

	task automatic pick_fraction(output logic [W-1:0] n, output logic [W-1:0] d);
		int unsigned sel, g, f0, f1, t;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			n = $urandom;
			d = $urandom;
		end else if (sel < 55) begin
			g = $urandom_range(1, 1000);
			n = $urandom_range(0, 1 << 20) * g;
			d = $urandom_range(1, 1 << 20) * g;
		end else if (sel < 68) begin
			n = $urandom_range(0, 40) - 20;
			d = $urandom_range(0, 40) - 20;
		end else if (sel < 78) begin
			n = EXTREMES[$urandom_range(0, 7)];
			d = EXTREMES[$urandom_range(0, 7)];
		end else if (sel < 88) begin
			f0 = 0;
			f1 = 1;
			repeat ($urandom_range(2, 45)) begin
				t = f0 + f1;
				f0 = f1;
				f1 = t;
			end
			n = f1;
			d = f0;
		end else if (sel < 97) begin
			n = $urandom_range(1, 255) << $urandom_range(0, 23);
			d = $urandom_range(1, 255) << $urandom_range(0, 23);
		end else begin
			n = $urandom;
			d = '0;
		end
		if ($urandom_range(0, 1)) n = -n;
		if ($urandom_range(0, 1)) d = -d;
	endtask

	task automatic offer_fraction(input logic [W-1:0] n, input logic [W-1:0] d,
		input logic typed, input frac_res_t res);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.numerator <= n;
		req_if.denominator <= d;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		reduced_q.push_back(typed ? res : reduce_fraction(n, d));
		sent_beats++;
		if (sent_beats % 64 == 0) send_idle = ($urandom_range(0, 3) != 0);
	endtask

	// stimulus
	initial begin
		logic [W-1:0] n, d;
		req_if.valid <= 1'b0;
		req_if.numerator <= '0;
		req_if.denominator <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			offer_fraction(DIRECTED[i].num, DIRECTED[i].den, DIRECTED[i].typed, DIRECTED[i].res);
		end
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == 300) rsp_hold_req = 1'b1;
			if (i == 600) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
				while (reduced_q.size() != 0) @(posedge clk);
			end
			pick_fraction(n, d);
			offer_fraction(n, d, 1'b0, NO_RES);
		end
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (reduced_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_fraction_reducer_top: PASS");
		end else begin
			$display("tb_fraction_reducer_top: FAIL");
		end
		$finish;
	end

	// result side
	initial begin
		frac_res_t   got, want;
		int unsigned gap, beats;
		bit          rsp_idle;
		beats = 0;
		rsp_idle = 1'b1;
		rsp_if.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = rsp_idle ? $urandom_range(0, 5) : 0;
			if (gap != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
			got.rnum = rsp_if.reduced_numerator;
			got.rden = rsp_if.reduced_denominator;
			got.whole = rsp_if.is_whole;
			got.dbz = rsp_if.div_by_zero;
			if (reduced_q.size() == 0) begin
				$display("%0t: unexpected beat, got %0d/%0d whole %0b dbz %0b", $time,
					got.rnum, got.rden, got.whole, got.dbz);
				mismatches++;
			end else begin
				want = reduced_q.pop_front();
				if (got.rnum !== want.rnum) begin
					$display("%0t: reduced_numerator expected %0d actual %0d", $time,
						want.rnum, got.rnum);
					mismatches++;
				end
				if (got.rden !== want.rden) begin
					$display("%0t: reduced_denominator expected %0d actual %0d", $time,
						want.rden, got.rden);
					mismatches++;
				end
				if (got.whole !== want.whole) begin
					$display("%0t: is_whole expected %0b actual %0b", $time,
						want.whole, got.whole);
					mismatches++;
				end
				if (got.dbz !== want.dbz) begin
					$display("%0t: div_by_zero expected %0b actual %0b", $time,
						want.dbz, got.dbz);
					mismatches++;
				end
			end
			beats++;
			if (beats % 64 == 0) rsp_idle = ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_fraction_reducer_top: FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
